/* hw/rtl/olist_pkg.sv */
// ----------------------------------------------------------------------------
// olist_pkg
// Shared sizes, operation and status codes, and sequencer states for the
// ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  // list capacity and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  // width that holds both a position and a length plus one
  localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // request operations
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_GET    = 3'd4
  } action_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_DEL,
    ST_LOC,
    ST_GET,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/ordered_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded position-ordered list of signed words with clear, insert, delete,
// locate and get requests, one result word per request.
// ----------------------------------------------------------------------------
// The list lives in a single-port-write, single-port-read RAM and a small
// sequencer walks it one entry per cycle through that one read port. A request
// is taken only while the sequencer is idle. Insert and delete walk only the
// entries from position p to the end, get reads one entry, locate stops at
// the first hit, and clear, errors and unused codes go straight to the result.
// The result sits in an output register, so the next request can be
// taken while the previous result still waits on out_ready. Entries past the
// current length are never read, so clear only resets the length.
`default_nettype none

module ordered_list_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [olist_pkg::ACT_W-1:0]  action,
  input  wire logic        [olist_pkg::POS_W-1:0]  position,
  input  wire logic signed [olist_pkg::WORD_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [olist_pkg::STAT_W-1:0] status,
  output logic signed      [olist_pkg::WORD_W-1:0] read_value,
  output logic             [olist_pkg::POS_W-1:0]  found_position,
  output logic             [olist_pkg::POS_W-1:0]  list_length
);

  localparam int IDX_W  = olist_pkg::IDX_W;
  localparam int CNT_W  = olist_pkg::CNT_W;
  localparam int WORD_W = olist_pkg::WORD_W;
  localparam int POS_W  = olist_pkg::POS_W;
  localparam int CMP_W  = olist_pkg::CMP_W;

  // control registers
  olist_pkg::state_t  state, state_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic               more, more_next;
  logic               pend, pend_next;
  logic               out_valid_reg, out_valid_next;

  // payload registers
  logic [IDX_W-1:0]   idx, idx_next;
  logic [IDX_W-1:0]   end_idx, end_idx_next;
  logic [IDX_W-1:0]   pend_addr, pend_addr_next;
  logic [IDX_W-1:0]   tgt, tgt_next;
  logic [WORD_W-1:0]  val_reg, val_reg_next;
  olist_pkg::status_t res_status, res_status_next;
  logic [WORD_W-1:0]  res_read, res_read_next;
  logic [POS_W-1:0]   res_found, res_found_next;
  olist_pkg::status_t out_status, out_status_next;
  logic [WORD_W-1:0]  out_read, out_read_next;
  logic [POS_W-1:0]   out_found, out_found_next;
  logic [POS_W-1:0]   out_length, out_length_next;

  // ram ports
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [WORD_W-1:0]  wdata;
  logic [IDX_W-1:0]   raddr;
  logic [WORD_W-1:0]  rdata;

  // request decode helpers
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   n_ext;
  logic               pos_zero;
  logic [IDX_W-1:0]   pos_idx;
  logic [IDX_W-1:0]   n_idx_m1;

  assign pos_ext  = CMP_W'(position);
  assign n_ext    = CMP_W'(fill_count);
  assign pos_zero = (position == '0);
  assign pos_idx  = IDX_W'(position - POS_W'(1));
  assign n_idx_m1 = IDX_W'(fill_count - CNT_W'(1));

  olist_ram #(
    .WORDS (olist_pkg::DEPTH),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= olist_pkg::ST_IDLE;
      fill_count    <= '0;
      more          <= 1'b0;
      pend          <= 1'b0;
      out_valid_reg <= 1'b0;
    end else begin
      state         <= state_next;
      fill_count    <= fill_count_next;
      more          <= more_next;
      pend          <= pend_next;
      out_valid_reg <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    end_idx    <= end_idx_next;
    pend_addr  <= pend_addr_next;
    tgt        <= tgt_next;
    val_reg    <= val_reg_next;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    res_found  <= res_found_next;
    out_status <= out_status_next;
    out_read   <= out_read_next;
    out_found  <= out_found_next;
    out_length <= out_length_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    more_next       = more;
    pend_next       = 1'b0;
    out_valid_next  = out_valid_reg && !out_ready;
    idx_next        = idx;
    end_idx_next    = end_idx;
    pend_addr_next  = pend_addr;
    tgt_next        = tgt;
    val_reg_next    = val_reg;
    res_status_next = res_status;
    res_read_next   = res_read;
    res_found_next  = res_found;
    out_status_next = out_status;
    out_read_next   = out_read;
    out_found_next  = out_found;
    out_length_next = out_length;
    raddr           = idx;
    we              = 1'b0;
    waddr           = pend_addr;
    wdata           = rdata;
    in_ready        = (state == olist_pkg::ST_IDLE);

    case (state)
      // take a request, check range and set up the walk
      olist_pkg::ST_IDLE: begin
        if (in_valid) begin
          val_reg_next    = value;
          tgt_next        = pos_idx;
          res_status_next = olist_pkg::STAT_OK;
          res_read_next   = '0;
          res_found_next  = '0;
          state_next      = olist_pkg::ST_RESP;
          case (olist_pkg::action_t'(action))
            olist_pkg::ACT_CLEAR: begin
              fill_count_next = '0;
            end
            olist_pkg::ACT_INSERT: begin
              if (pos_zero || (pos_ext > n_ext + CMP_W'(1))) begin
                res_status_next = olist_pkg::STAT_RANGE;
              end else if (fill_count == CNT_W'(olist_pkg::DEPTH)) begin
                res_status_next = olist_pkg::STAT_FULL;
              end else begin
                idx_next     = n_idx_m1;
                end_idx_next = pos_idx;
                more_next    = (n_ext >= pos_ext);
                state_next   = olist_pkg::ST_INS;
              end
            end
            olist_pkg::ACT_DELETE: begin
              if (pos_zero || (pos_ext > n_ext)) begin
                res_status_next = olist_pkg::STAT_RANGE;
              end else begin
                idx_next     = pos_idx;
                end_idx_next = n_idx_m1;
                more_next    = 1'b1;
                state_next   = olist_pkg::ST_DEL;
              end
            end
            olist_pkg::ACT_LOCATE: begin
              idx_next     = '0;
              end_idx_next = n_idx_m1;
              more_next    = (fill_count != '0);
              state_next   = olist_pkg::ST_LOC;
            end
            olist_pkg::ACT_GET: begin
              if (pos_zero || (pos_ext > n_ext)) begin
                res_status_next = olist_pkg::STAT_RANGE;
              end else begin
                idx_next     = pos_idx;
                end_idx_next = pos_idx;
                more_next    = 1'b1;
                state_next   = olist_pkg::ST_GET;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // shift up: read from the top down, write each word one slot higher
      olist_pkg::ST_INS: begin
        if (more) begin
          pend_next      = 1'b1;
          pend_addr_next = idx;
          idx_next       = idx - IDX_W'(1);
          more_next      = (idx != end_idx);
        end
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr + IDX_W'(1);
        end
        if (!more) begin
          state_next = olist_pkg::ST_PUT;
        end
      end

      // drop the new word into the opened slot
      olist_pkg::ST_PUT: begin
        we              = 1'b1;
        waddr           = tgt;
        wdata           = val_reg;
        fill_count_next = fill_count + CNT_W'(1);
        state_next      = olist_pkg::ST_RESP;
      end

      // shift down: first read is the removed word, the rest move down one
      olist_pkg::ST_DEL: begin
        if (more) begin
          pend_next      = 1'b1;
          pend_addr_next = idx;
          idx_next       = idx + IDX_W'(1);
          more_next      = (idx != end_idx);
        end
        if (pend) begin
          if (pend_addr == tgt) begin
            res_read_next = rdata;
          end else begin
            we    = 1'b1;
            waddr = pend_addr - IDX_W'(1);
          end
        end
        if (!more) begin
          fill_count_next = fill_count - CNT_W'(1);
          state_next      = olist_pkg::ST_RESP;
        end
      end

      // single read of the requested slot
      olist_pkg::ST_GET: begin
        if (more) begin
          pend_next      = 1'b1;
          pend_addr_next = idx;
          more_next      = 1'b0;
        end
        if (pend) begin
          res_read_next = rdata;
        end
        if (!more) begin
          state_next = olist_pkg::ST_RESP;
        end
      end

      // scan from the front, stop at the first match
      olist_pkg::ST_LOC: begin
        if (pend && (rdata == val_reg)) begin
          res_found_next = POS_W'(CNT_W'(pend_addr) + CNT_W'(1));
          more_next      = 1'b0;
          state_next     = olist_pkg::ST_RESP;
        end else begin
          if (more) begin
            pend_next      = 1'b1;
            pend_addr_next = idx;
            idx_next       = idx + IDX_W'(1);
            more_next      = (idx != end_idx);
          end else begin
            res_status_next = olist_pkg::STAT_NOTFOUND;
            state_next      = olist_pkg::ST_RESP;
          end
        end
      end

      // hand the result word to the output register once it is free
      olist_pkg::ST_RESP: begin
        if (!out_valid_reg || out_ready) begin
          out_status_next = res_status;
          out_read_next   = res_read;
          out_found_next  = res_found;
          out_length_next = POS_W'(fill_count);
          out_valid_next  = 1'b1;
          state_next      = olist_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = olist_pkg::ST_IDLE;
      end
    endcase
  end

  // output word
  assign out_valid      = out_valid_reg;
  assign status         = out_status;
  assign read_value     = out_read;
  assign found_position = out_found;
  assign list_length    = out_length;

endmodule

`default_nettype wire

/* hw/rtl/olist_ram.sv */
// ----------------------------------------------------------------------------
// olist_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_ram #(
  parameter int WORDS = 64,
  parameter int WIDTH = 32,
  localparam int AW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
